@@ rtl/asr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// asr_pkg
// Shared constants and controller/datapath signal groups for the sorter.
// ----------------------------------------------------------------------------
package asr_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int VALUE_W      = 32;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;    // capture request value, target slot = count, read count-1
        logic set_ovf;   // drop request, flag overflow
        logic shift;     // move read element up one slot, read the next lower one
        logic place;     // write held value at target slot, bump count
        logic emit_rd;   // read element at emit index
        logic emit_adv;  // advance emit index
        logic emit_done; // clear count, overflow and emit index
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic full;       // store holds CAPACITY elements
        logic count_zero; // store empty
        logic pos_one;    // target slot is 1
        logic greater;    // element read is greater than the held value
        logic emit_last;  // emit index points at the final element
    } status_t;

endpackage
`default_nettype wire

@@ rtl/asr_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// asr_dpath
// Element store, insertion pointers, emit index and result register.
// ----------------------------------------------------------------------------
module asr_dpath #(
    parameter int CAPACITY = asr_pkg::CAPACITY_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire asr_pkg::cmd_t                 cmd,
    output asr_pkg::status_t                   status,
    input  wire logic [asr_pkg::VALUE_W-1:0]   in_value,
    output logic      [asr_pkg::VALUE_W-1:0]   out_value,
    output logic                               out_last,
    output logic                               out_ovf
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C  = CW'(1);
    localparam logic [AW-1:0] ONE_A  = AW'(1);
    localparam logic [AW-1:0] TWO_A  = AW'(2);

    logic [asr_pkg::VALUE_W-1:0] mem [CAPACITY];

    logic [asr_pkg::VALUE_W-1:0] val_reg;
    logic [asr_pkg::VALUE_W-1:0] rd_data_reg;
    logic [CW-1:0]               count_reg, count_next;
    logic                        ovf_reg, ovf_next;
    logic [AW-1:0]               pos_reg, pos_next;
    logic [AW-1:0]               k_reg, k_next;

    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [asr_pkg::VALUE_W-1:0] wr_data;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [CW-1:0]               count_m1;

    assign count_m1 = count_reg - ONE_C;

    // Memory port control
    always_comb begin
        wr_en   = cmd.shift | cmd.place;
        wr_addr = pos_reg;
        wr_data = cmd.shift ? rd_data_reg : val_reg;
        rd_en   = 1'b0;
        rd_addr = k_reg;
        if (cmd.accept) begin
            rd_en   = (count_reg != '0);
            rd_addr = count_m1[AW-1:0];
        end else if (cmd.shift) begin
            rd_en   = (pos_reg != ONE_A);
            rd_addr = pos_reg - TWO_A;
        end else if (cmd.emit_rd) begin
            rd_en   = 1'b1;
            rd_addr = k_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (cmd.accept) begin
            val_reg <= in_value;
        end
    end

    // Counters and pointers
    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        pos_next   = pos_reg;
        k_next     = k_reg;
        if (cmd.accept) begin
            pos_next = count_reg[AW-1:0];
        end
        if (cmd.shift) begin
            pos_next = pos_reg - ONE_A;
        end
        if (cmd.place) begin
            count_next = count_reg + ONE_C;
        end
        if (cmd.set_ovf) begin
            ovf_next = 1'b1;
        end
        if (cmd.emit_adv) begin
            k_next = k_reg + ONE_A;
        end
        if (cmd.emit_done) begin
            count_next = '0;
            ovf_next   = 1'b0;
            k_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            pos_reg   <= '0;
            k_reg     <= '0;
        end else begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            pos_reg   <= pos_next;
            k_reg     <= k_next;
        end
    end

    always_comb begin
        status.full       = (count_reg == CAP_C);
        status.count_zero = (count_reg == '0);
        status.pos_one    = (pos_reg == ONE_A);
        status.greater    = ($signed(rd_data_reg) > $signed(val_reg));
        status.emit_last  = ({{(CW-AW){1'b0}}, k_reg} == count_m1);
    end

    assign out_value = rd_data_reg;
    assign out_last  = status.emit_last;
    assign out_ovf   = ovf_reg;

endmodule
`default_nettype wire

@@ rtl/asr_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// asr_ctrl
// Sequencer for insertion on load and in-order readout on emit.
// ----------------------------------------------------------------------------
module asr_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic             s_tlast,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output asr_pkg::cmd_t         cmd,
    input  wire asr_pkg::status_t status
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SHIFT    = 3'd1;
    localparam logic [2:0] S_PLACE    = 3'd2;
    localparam logic [2:0] S_EMIT_RD  = 3'd3;
    localparam logic [2:0] S_EMIT_OUT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       last_reg, last_next;

    always_comb begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (status.full) begin
                        cmd.set_ovf = 1'b1;
                        state_next  = s_tlast ? S_EMIT_RD : S_IDLE;
                    end else begin
                        cmd.accept = 1'b1;
                        last_next  = s_tlast;
                        state_next = status.count_zero ? S_PLACE : S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                if (status.greater) begin
                    cmd.shift  = 1'b1;
                    state_next = status.pos_one ? S_PLACE : S_SHIFT;
                end else begin
                    cmd.place  = 1'b1;
                    state_next = last_reg ? S_EMIT_RD : S_IDLE;
                end
            end
            S_PLACE: begin
                cmd.place  = 1'b1;
                state_next = last_reg ? S_EMIT_RD : S_IDLE;
            end
            S_EMIT_RD: begin
                cmd.emit_rd = 1'b1;
                state_next  = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (status.emit_last) begin
                        cmd.emit_done = 1'b1;
                        state_next    = S_IDLE;
                    end else begin
                        cmd.emit_adv = 1'b1;
                        state_next   = S_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/ascending_sorter_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ascending_sorter_core
// Streaming sorter: loads a list of signed 32-bit values, emits it ascending.
// ----------------------------------------------------------------------------
// A list arrives one value per request on the s_ side; the request with
// s_tlast high closes it. Each value is inserted into a CAPACITY-entry store
// kept in ascending order (equal values go after those already held), so a
// load request holds off the next one while every held value greater than
// the new one is moved up one slot: the store has one read and one write
// port, and elements are moved one at a time. After the closing request the
// list comes out on the m_ side in ascending order, each result read from
// the store and then presented until the sink takes it, with m_tlast
// on the final value. Values beyond CAPACITY are dropped, and every result of
// that list then carries the overflow flag in m_tuser. The store needs no
// clearing after reset; only entries written for the current list are read.
// ----------------------------------------------------------------------------
module ascending_sorter_core #(
    parameter int CAPACITY = asr_pkg::CAPACITY_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic        s_tlast,   // last
    // result out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] sorted_value
    output logic             m_tlast,   // last_out
    output logic [0:0]       m_tuser    // [0] overflow
);

    asr_pkg::cmd_t    cmd;
    asr_pkg::status_t status;
    logic             out_ovf;

    // Sequence insertion and readout
    asr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    // Hold the sorted store, pointers and the presented result
    asr_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_value  (s_tdata),
        .out_value (m_tdata),
        .out_last  (m_tlast),
        .out_ovf   (out_ovf)
    );

    assign m_tuser = out_ovf;

endmodule
`default_nettype wire

@@ test/tb_ascending_sorter_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ascending_sorter_core
// Streams signed lists into the sorter and checks every sorted result.
// ----------------------------------------------------------------------------
// Each accepted request updates a local model of the list being loaded; the
// closing request turns it into the expected ascending sequence, with the
// overflow flag where values were dropped. Lists run from one value up to
// past the store size, under bursty input and a stalling sink.
// ----------------------------------------------------------------------------
module tb_ascending_sorter_core;

    localparam int CAPACITY = asr_pkg::CAPACITY_DEF;
    localparam int LIST_ITEMS = 200;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } list_item_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
        logic               ovf;
    } sorted_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;

    list_item_t         pending_items[$];
    sorted_item_t       sorted_expect[$];
    logic signed [31:0] held_values[$];
    logic               held_overflow = 1'b0;

    int  mismatch_count = 0;
    int  loads_accepted = 0;
    int  burst_left = 1;
    int  gap_left = 0;
    int  rx_mode = 0;
    int  rx_left = 0;
    logic hold_off = 1'b0;

    ascending_sorter_core #(.CAPACITY(CAPACITY)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Insert one accepted value in order (equal values after those held);
    // on the closing request release the whole list as expected results.
    function void load_value(input logic signed [31:0] v, input logic is_last);
        int pos;
        sorted_item_t r;
        if (held_values.size() < CAPACITY) begin
            pos = held_values.size();
            for (int i = 0; i < held_values.size(); i++) begin
                if (held_values[i] > v) begin
                    pos = i;
                    break;
                end
            end
            held_values.insert(pos, v);
        end else begin
            held_overflow = 1'b1;
        end
        if (is_last) begin
            for (int k = 0; k < held_values.size(); k++) begin
                r.value = held_values[k];
                r.last  = (k == held_values.size() - 1);
                r.ovf   = held_overflow;
                sorted_expect.push_back(r);
            end
            held_values.delete();
            held_overflow = 1'b0;
        end
    endfunction

    function void add_item(input logic signed [31:0] v, input logic is_last);
        list_item_t it;
        it.value = v;
        it.last  = is_last;
        pending_items.push_back(it);
    endfunction

    // Mix of full-range, clustered (many duplicates) and extreme values.
    function logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(0, 3))
            0: v = $signed($urandom_range(0, 16)) - 8;
            1: begin
                case ($urandom_range(0, 5))
                    0: v = VAL_MIN;
                    1: v = VAL_MAX;
                    2: v = VAL_MIN + 1;
                    3: v = VAL_MAX - 1;
                    4: v = 0;
                    default: v = -1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function void add_list(input int len);
        for (int i = 0; i < len; i++)
            add_item(pick_value(), i == len - 1);
    endfunction

    // Sender: bursts of random length with random gaps; hold a request until
    // it is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                load_value($signed(s_tdata), s_tlast);
                void'(pending_items.pop_front());
                loads_accepted++;
            end
            if (s_tvalid && !s_tready) begin
                // hold the current request
            end else if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_items[0].value;
                s_tlast  <= pending_items[0].last;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Sink: switch between always-ready, mostly-ready and mostly-stalled.
    always @(posedge aclk) begin : sink_pattern
        logic ready_next;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_left = $urandom_range(8, 80);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                0: ready_next = 1'b1;
                1: ready_next = ($urandom_range(0, 3) != 0);
                default: ready_next = ($urandom_range(0, 3) == 0);
            endcase
            m_tready <= hold_off ? 1'b0 : ready_next;
        end
    end

    // Long sink hold-off while requests keep coming, so the input backs up.
    initial begin
        wait (loads_accepted >= 40);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (400) @(posedge aclk);
        hold_off <= 1'b0;
    end

    always @(posedge aclk) begin : result_check
        sorted_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (sorted_expect.size() == 0) begin
                if (mismatch_count < 10)
                    $display("%0t: unexpected result value=%0d last=%0b ovf=%0b",
                             $time, $signed(m_tdata), m_tlast, m_tuser[0]);
                mismatch_count++;
            end else begin
                want = sorted_expect.pop_front();
                if (m_tdata !== want.value || m_tlast !== want.last ||
                    m_tuser[0] !== want.ovf) begin
                    if (mismatch_count < 10)
                        $display("%0t: mismatch exp value=%0d last=%0b ovf=%0b, got value=%0d last=%0b ovf=%0b",
                                 $time, want.value, want.last, want.ovf,
                                 $signed(m_tdata), m_tlast, m_tuser[0]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int list_no;
        int len;

        // Directed lists: single extremes, mixed signs, duplicates,
        // descending (every value moves the whole store) and ascending.
        add_item(VAL_MIN, 1'b1);
        add_item(VAL_MAX, 1'b1);
        add_item(VAL_MAX, 1'b0);
        add_item(VAL_MIN, 1'b0);
        add_item(0, 1'b0);
        add_item(-1, 1'b0);
        add_item(1, 1'b0);
        add_item(32'sh5555_5555, 1'b1);
        add_item(7, 1'b0);
        add_item(-3, 1'b0);
        add_item(7, 1'b0);
        add_item(7, 1'b0);
        add_item(-3, 1'b1);
        for (int i = 5; i >= 0; i--)
            add_item(i, i == 0);
        for (int i = -2; i <= 1; i++)
            add_item(i, i == 1);

        // Random lists, mostly short; three fill the store exactly or run past
        // it, including one where only the closing value is dropped.
        list_no = 0;
        while (list_no < 6 || pending_items.size() < LIST_ITEMS) begin
            list_no++;
            if (list_no == 2) begin
                add_list(CAPACITY);
            end else if (list_no == 4) begin
                add_list(CAPACITY + 1);
            end else if (list_no == 6) begin
                add_list(CAPACITY + $urandom_range(2, 8));
            end else begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 24)
                                                  : $urandom_range(1, 12);
                add_list(len);
            end
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_items.size() == 0 && !s_tvalid);
        while (sorted_expect.size() != 0) @(posedge aclk);
        repeat (CAPACITY * 3) @(posedge aclk);

        if (mismatch_count == 0 && sorted_expect.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/asr_pkg.sv
rtl/asr_dpath.sv
rtl/asr_ctrl.sv
rtl/ascending_sorter_core.sv
test/tb_ascending_sorter_core.sv
